FILE: rtl/mfqs_pkg.sv
// shared constants, codes and controller/datapath interface types
// of the four-level feedback queue scheduler; no dependencies
`default_nettype none

package mfqs_pkg;

   // sizes
   localparam int MAX_PROC    = 16;
   localparam int SLOT_W      = 4;
   localparam int CNT_W       = 5;
   localparam int TIME_W      = 16;
   localparam int POS_W       = 5;
   localparam int BURST_SLOTS = 32;
   localparam int LVL_W       = 2;
   localparam int BADDR_W     = SLOT_W + POS_W;
   localparam int FADDR_W     = LVL_W + SLOT_W;
   localparam int BURST_DEPTH = MAX_PROC * BURST_SLOTS;
   localparam int FIFO_DEPTH  = 4 * MAX_PROC;

   localparam logic [TIME_W-1:0] TIME_TOP = '1;

   // input actions
   localparam logic [1:0] ACT_DEFINE = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // result events
   localparam logic [2:0] EV_TERM   = 3'd0;
   localparam logic [2:0] EV_SLEEP  = 3'd1;
   localparam logic [2:0] EV_RUNOUT = 3'd2;
   localparam logic [2:0] EV_ENQ    = 3'd3;
   localparam logic [2:0] EV_DISP   = 3'd4;
   localparam logic [2:0] EV_DONE   = 3'd5;

   // enqueue causes
   localparam logic [1:0] CAUSE_CREATED = 2'd0;
   localparam logic [1:0] CAUSE_PREEMPT = 2'd1;
   localparam logic [1:0] CAUSE_WAKE    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_PCOUNT = 2'd0;
   localparam logic [1:0] CSR_Q0     = 2'd1;
   localparam logic [1:0] CSR_Q1     = 2'd2;
   localparam logic [1:0] CSR_Q2     = 2'd3;

   // levels
   localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
   localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
   localparam logic [LVL_W-1:0] LVL_2 = 2'd2;
   localparam logic [LVL_W-1:0] LVL_3 = 2'd3;

   // datapath operations
   localparam logic [4:0] OP_NONE    = 5'd0;
   localparam logic [4:0] OP_LATCH   = 5'd1;
   localparam logic [4:0] OP_DEFINE  = 5'd2;
   localparam logic [4:0] OP_CLEAR   = 5'd3;
   localparam logic [4:0] OP_LOAD    = 5'd4;
   localparam logic [4:0] OP_SUM_RD  = 5'd5;
   localparam logic [4:0] OP_SUM_ACC = 5'd6;
   localparam logic [4:0] OP_SUM_FIN = 5'd7;
   localparam logic [4:0] OP_TERM    = 5'd8;
   localparam logic [4:0] OP_TIMEOUT = 5'd9;
   localparam logic [4:0] OP_RUN     = 5'd10;
   localparam logic [4:0] OP_IO_RD   = 5'd11;
   localparam logic [4:0] OP_IO_CAP  = 5'd12;
   localparam logic [4:0] OP_SLEEP   = 5'd13;
   localparam logic [4:0] OP_SCAN    = 5'd14;
   localparam logic [4:0] OP_DISP_RD = 5'd15;
   localparam logic [4:0] OP_DISP    = 5'd16;
   localparam logic [4:0] OP_DONE    = 5'd17;

   // slot address source for the per-slot record
   localparam logic [1:0] SEL_REQ  = 2'd0;
   localparam logic [1:0] SEL_RUN  = 2'd1;
   localparam logic [1:0] SEL_SCAN = 2'd2;
   localparam logic [1:0] SEL_FIFO = 2'd3;

   typedef struct packed {
      logic [4:0]       op;
      logic [1:0]       sel;
      logic [CNT_W-1:0] idx;
   } mfqs_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       slice_zero;
      logic       slice_one;
      logic       rem_le1;
      logic       ends;
      logic       scan_live;
      logic       scan_hit;
      logic       sum_more;
      logic       pos_ok;
      logic       disp_any;
      logic       out_free;
   } mfqs_status_type;

endpackage

`default_nettype wire

FILE: rtl/mfqs_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module mfqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/mfqs_ctrl.sv
// sequencing state machine of the scheduler
// depends on mfqs_pkg; drives the datapath through the command struct
`default_nettype none

module mfqs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire mfqs_pkg::mfqs_status_type status,
   output mfqs_pkg::mfqs_cmd_type         cmd
);
   import mfqs_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_DEFCLR  = 5'd2;
   localparam logic [4:0] S_LDWR    = 5'd3;
   localparam logic [4:0] S_SUMRD   = 5'd4;
   localparam logic [4:0] S_SUMWAIT = 5'd5;
   localparam logic [4:0] S_SUMACC  = 5'd6;
   localparam logic [4:0] S_CHG     = 5'd7;
   localparam logic [4:0] S_IORD    = 5'd8;
   localparam logic [4:0] S_IOWAIT  = 5'd9;
   localparam logic [4:0] S_IOCAP   = 5'd10;
   localparam logic [4:0] S_NXWAIT  = 5'd11;
   localparam logic [4:0] S_SLEEP   = 5'd12;
   localparam logic [4:0] S_SCAN    = 5'd13;
   localparam logic [4:0] S_DCHK    = 5'd14;
   localparam logic [4:0] S_DWAIT   = 5'd15;
   localparam logic [4:0] S_DISP    = 5'd16;
   localparam logic [4:0] S_DONE    = 5'd17;

   localparam logic [CNT_W-1:0] IDX_LAST = '1;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         S_DECODE, S_DEFCLR, S_LDWR, S_SUMRD, S_SUMWAIT, S_SUMACC: cmd.sel = SEL_REQ;
         S_SCAN:  cmd.sel = SEL_SCAN;
         S_DISP:  cmd.sel = SEL_FIFO;
         default: cmd.sel = SEL_RUN;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in = '0;
            unique case (status.action)
               ACT_DEFINE: begin
                  cmd.op   = OP_DEFINE;
                  state_in = S_DEFCLR;
               end
               ACT_LOAD: state_in = S_LDWR;
               ACT_TICK: state_in = S_CHG;
               default:  state_in = S_IDLE;
            endcase
         end
         // zero the burst row, one entry a cycle
         S_DEFCLR: begin
            cmd.op = OP_CLEAR;
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == IDX_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_LDWR: begin
            if (status.pos_ok) begin
               cmd.op   = OP_LOAD;
               state_in = S_SUMRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         // cpu total: walk the even burst entries
         S_SUMRD: begin
            if (status.sum_more) begin
               cmd.op   = OP_SUM_RD;
               state_in = S_SUMWAIT;
            end else begin
               cmd.op   = OP_SUM_FIN;
               state_in = S_IDLE;
            end
         end
         S_SUMWAIT: state_in = S_SUMACC;
         S_SUMACC: begin
            cmd.op   = OP_SUM_ACC;
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_SUMRD;
         end
         // charge the running burst
         S_CHG: begin
            if (status.slice_zero) begin
               state_in = S_SCAN;
            end else if (status.rem_le1) begin
               if (!status.ends) begin
                  state_in = S_IORD;
               end else if (status.out_free) begin
                  cmd.op   = OP_TERM;
                  state_in = S_SCAN;
               end
            end else if (status.slice_one) begin
               if (status.out_free) begin
                  cmd.op   = OP_TIMEOUT;
                  state_in = S_SCAN;
               end
            end else begin
               cmd.op   = OP_RUN;
               state_in = S_SCAN;
            end
         end
         S_IORD: begin
            cmd.op   = OP_IO_RD;
            state_in = S_IOWAIT;
         end
         S_IOWAIT: state_in = S_IOCAP;
         S_IOCAP: begin
            cmd.op   = OP_IO_CAP;
            state_in = S_NXWAIT;
         end
         S_NXWAIT: state_in = S_SLEEP;
         S_SLEEP: begin
            if (status.out_free) begin
               cmd.op   = OP_SLEEP;
               state_in = S_SCAN;
            end
         end
         // enqueue scan over slots in use
         S_SCAN: begin
            if (!status.scan_live) begin
               state_in = S_DCHK;
            end else if (!status.scan_hit) begin
               idx_in = idx_ff + CNT_W'(1);
            end else if (status.out_free) begin
               cmd.op = OP_SCAN;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_DCHK: begin
            if (status.slice_zero && status.disp_any) begin
               cmd.op   = OP_DISP_RD;
               state_in = S_DWAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DWAIT: state_in = S_DISP;
         S_DISP: begin
            if (status.out_free) begin
               cmd.op   = OP_DISP;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mfqs_dp.sv
// datapath: process records, ready queues, burst memory, time and result register
// depends on mfqs_pkg and mfqs_ram
`default_nettype none

module mfqs_dp (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mfqs_pkg::mfqs_cmd_type    cmd,
   output mfqs_pkg::mfqs_status_type      status,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [15:0]               csr_wdata,
   input  wire logic [1:0]                req_action,
   input  wire logic [3:0]                req_process_index,
   input  wire logic [15:0]               req_arrival_time,
   input  wire logic [1:0]                req_start_level,
   input  wire logic [4:0]                req_cpu_burst_count,
   input  wire logic [4:0]                req_burst_slot,
   input  wire logic [15:0]               req_burst_length,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [2:0]                     rsp_event_res,
   output logic [3:0]                     rsp_process_number,
   output logic [1:0]                     rsp_queue_level,
   output logic [1:0]                     rsp_enqueue_cause,
   output logic [15:0]                    rsp_event_time,
   output logic [15:0]                    rsp_turnaround_time,
   output logic [15:0]                    rsp_waiting_time,
   output logic                           rsp_all_finished,
   output logic                           rsp_last
);
   import mfqs_pkg::*;

   // configuration
   logic [CNT_W-1:0]  pcount_ff;
   logic [TIME_W-1:0] q0_ff, q1_ff, q2_ff;

   // latched item
   logic [1:0]        rq_act_ff;
   logic [SLOT_W-1:0] rq_slot_ff;
   logic [TIME_W-1:0] rq_arr_ff;
   logic [LVL_W-1:0]  rq_lvl_ff;
   logic [CNT_W-1:0]  rq_cnt_ff;
   logic [POS_W-1:0]  rq_pos_ff;
   logic [TIME_W-1:0] rq_len_ff;

   // scheduler state
   logic [TIME_W-1:0] cur_ff, cur_in;
   logic [TIME_W-1:0] slice_ff, slice_in;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic [MAX_PROC-1:0] active_ff, active_in, pending_ff, pending_in;
   logic [SLOT_W-1:0] head_ff [4];
   logic [SLOT_W-1:0] head_in [4];
   logic [CNT_W-1:0]  count_ff [4];
   logic [CNT_W-1:0]  count_in [4];

   // per-slot records
   logic [LVL_W-1:0]  level_ff [MAX_PROC];
   logic [LVL_W-1:0]  level_in [MAX_PROC];
   logic [TIME_W-1:0] next_ff  [MAX_PROC];
   logic [TIME_W-1:0] next_in  [MAX_PROC];
   logic [1:0]        cause_ff [MAX_PROC];
   logic [1:0]        cause_in [MAX_PROC];
   logic [CNT_W-1:0]  bl_ff    [MAX_PROC];
   logic [CNT_W-1:0]  bl_in    [MAX_PROC];
   logic [POS_W-1:0]  ptr_ff   [MAX_PROC];
   logic [POS_W-1:0]  ptr_in   [MAX_PROC];
   logic [TIME_W-1:0] rem_ff   [MAX_PROC];
   logic [TIME_W-1:0] rem_in   [MAX_PROC];
   logic [TIME_W-1:0] fa_ff    [MAX_PROC];
   logic [TIME_W-1:0] fa_in    [MAX_PROC];
   logic [TIME_W-1:0] tot_ff   [MAX_PROC];
   logic [TIME_W-1:0] tot_in   [MAX_PROC];

   // scratch
   logic [TIME_W-1:0]  sum_ff, sum_in, io_ff, io_in;
   logic [LVL_W-1:0]   lsel_ff, lsel_in;
   logic [BADDR_W-1:0] brd_ff, brd_in;
   logic [FADDR_W-1:0] frd_ff, frd_in;

   // memories
   logic               bwe, fwe;
   logic [BADDR_W-1:0] bwaddr;
   logic [TIME_W-1:0]  bwdata, bdata;
   logic [FADDR_W-1:0] fwaddr;
   logic [SLOT_W-1:0]  fwdata, fdata;

   // result
   logic              emit;
   logic [2:0]        e_ev;
   logic [SLOT_W-1:0] e_num;
   logic [LVL_W-1:0]  e_lvl;
   logic [1:0]        e_cause;
   logic [TIME_W-1:0] e_tt, e_wt;
   logic              e_last;
   logic              rsp_valid_ff;

   // record read port
   logic [SLOT_W-1:0] a;
   logic [LVL_W-1:0]  lvl_a, lvl_up, lvl_wake;
   logic [TIME_W-1:0] rem_a, b_a, q_sel, tt, wt;
   logic [CNT_W-1:0]  bl_a, n_use, cnt_clamp;
   logic [POS_W-1:0]  ptr_a;
   logic [MAX_PROC-1:0] use_mask;
   logic [LVL_W-1:0]  lvl_pick;
   logic [TIME_W:0]   wake_sum, acc_sum;

   mfqs_ram #(.WIDTH(TIME_W), .DEPTH(BURST_DEPTH)) u_burst (
      .clock(clock), .wr_en(bwe), .wr_addr(bwaddr), .wr_data(bwdata),
      .rd_addr(brd_ff), .rd_data(bdata)
   );

   mfqs_ram #(.WIDTH(SLOT_W), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .wr_en(fwe), .wr_addr(fwaddr), .wr_data(fwdata),
      .rd_addr(frd_ff), .rd_data(fdata)
   );

   // slot address for the record port
   always_comb begin
      unique case (cmd.sel)
         SEL_REQ:  a = rq_slot_ff;
         SEL_SCAN: a = cmd.idx[SLOT_W-1:0];
         SEL_FIFO: a = fdata;
         default:  a = run_ff;
      endcase
   end

   assign lvl_a = level_ff[a];
   assign rem_a = rem_ff[a];
   assign bl_a  = bl_ff[a];
   assign ptr_a = ptr_ff[a];

   // slots in use
   assign n_use = (pcount_ff > CNT_W'(MAX_PROC)) ? CNT_W'(MAX_PROC) : pcount_ff;
   always_comb begin
      for (int i = 0; i < MAX_PROC; i++) begin
         use_mask[i] = (CNT_W'(i) < n_use);
      end
   end

   // highest non-empty level
   always_comb begin
      if (count_ff[0] != '0)      lvl_pick = LVL_0;
      else if (count_ff[1] != '0) lvl_pick = LVL_1;
      else if (count_ff[2] != '0) lvl_pick = LVL_2;
      else                        lvl_pick = LVL_3;
   end

   // slice for the level being dispatched
   always_comb begin
      case (lsel_ff)
         LVL_0:   q_sel = q0_ff;
         LVL_1:   q_sel = q1_ff;
         default: q_sel = q2_ff;
      endcase
      if (q_sel == '0) q_sel = TIME_W'(1);
   end

   assign b_a       = (rem_a == '0) ? TIME_W'(1) : rem_a;
   assign tt        = (cur_ff >= fa_ff[a]) ? cur_ff - fa_ff[a] : '0;
   assign wt        = (tt >= tot_ff[a]) ? tt - tot_ff[a] : '0;
   assign lvl_up    = (lvl_a == LVL_3) ? LVL_3 : lvl_a + LVL_W'(1);
   assign lvl_wake  = (lvl_a == LVL_1) ? LVL_0 : (lvl_a == LVL_2) ? LVL_1 : lvl_a;
   assign wake_sum  = {1'b0, cur_ff} + {1'b0, io_ff};
   assign acc_sum   = {1'b0, sum_ff} + {1'b0, bdata};
   assign cnt_clamp = (rq_cnt_ff == '0) ? CNT_W'(1)
                    : (rq_cnt_ff > CNT_W'(MAX_PROC)) ? CNT_W'(MAX_PROC) : rq_cnt_ff;

   // operation decode
   always_comb begin
      cur_in     = cur_ff;
      slice_in   = slice_ff;
      run_in     = run_ff;
      active_in  = active_ff;
      pending_in = pending_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      level_in   = level_ff;
      next_in    = next_ff;
      cause_in   = cause_ff;
      bl_in      = bl_ff;
      ptr_in     = ptr_ff;
      rem_in     = rem_ff;
      fa_in      = fa_ff;
      tot_in     = tot_ff;
      sum_in     = sum_ff;
      io_in      = io_ff;
      lsel_in    = lsel_ff;
      brd_in     = brd_ff;
      frd_in     = frd_ff;
      bwe        = 1'b0;
      bwaddr     = {rq_slot_ff, rq_pos_ff};
      bwdata     = rq_len_ff;
      fwe        = 1'b0;
      fwaddr     = {lvl_a, head_ff[lvl_a] + count_ff[lvl_a][SLOT_W-1:0]};
      fwdata     = a;
      emit       = 1'b0;
      e_ev       = EV_DONE;
      e_num      = a;
      e_lvl      = lvl_a;
      e_cause    = CAUSE_CREATED;
      e_tt       = '0;
      e_wt       = '0;
      e_last     = 1'b0;
      case (cmd.op)
         OP_DEFINE: begin
            active_in[a]  = 1'b1;
            pending_in[a] = 1'b1;
            level_in[a]   = rq_lvl_ff;
            next_in[a]    = rq_arr_ff;
            cause_in[a]   = CAUSE_CREATED;
            bl_in[a]      = cnt_clamp;
            ptr_in[a]     = '0;
            rem_in[a]     = '0;
            fa_in[a]      = rq_arr_ff;
            tot_in[a]     = '0;
         end
         OP_CLEAR: begin
            bwe    = 1'b1;
            bwaddr = {rq_slot_ff, cmd.idx};
            bwdata = '0;
         end
         OP_LOAD: begin
            bwe = 1'b1;
            if (rq_pos_ff == ptr_a) rem_in[a] = rq_len_ff;
            sum_in = '0;
         end
         OP_SUM_RD:  brd_in = {rq_slot_ff, cmd.idx[SLOT_W-1:0], 1'b0};
         OP_SUM_ACC: sum_in = acc_sum[TIME_W] ? TIME_TOP : acc_sum[TIME_W-1:0];
         OP_SUM_FIN: tot_in[a] = sum_ff;
         OP_TERM: begin
            slice_in      = '0;
            rem_in[a]     = '0;
            bl_in[a]      = '0;
            active_in[a]  = 1'b0;
            pending_in[a] = 1'b0;
            emit          = 1'b1;
            e_ev          = EV_TERM;
            e_tt          = tt;
            e_wt          = wt;
         end
         OP_TIMEOUT: begin
            slice_in      = slice_ff - TIME_W'(1);
            rem_in[a]     = rem_a - TIME_W'(1);
            level_in[a]   = lvl_up;
            next_in[a]    = cur_ff;
            cause_in[a]   = CAUSE_PREEMPT;
            pending_in[a] = 1'b1;
            emit          = 1'b1;
            e_ev          = EV_RUNOUT;
            e_lvl         = lvl_up;
         end
         OP_RUN: begin
            slice_in  = slice_ff - TIME_W'(1);
            rem_in[a] = rem_a - TIME_W'(1);
         end
         OP_IO_RD: brd_in = {a, ptr_a + POS_W'(1)};
         OP_IO_CAP: begin
            io_in  = bdata;
            brd_in = {a, ptr_a + POS_W'(2)};
         end
         OP_SLEEP: begin
            slice_in      = '0;
            bl_in[a]      = bl_a - CNT_W'(1);
            ptr_in[a]     = ptr_a + POS_W'(2);
            rem_in[a]     = bdata;
            next_in[a]    = wake_sum[TIME_W] ? TIME_TOP : wake_sum[TIME_W-1:0];
            level_in[a]   = lvl_wake;
            cause_in[a]   = CAUSE_WAKE;
            pending_in[a] = 1'b1;
            emit          = 1'b1;
            e_ev          = EV_SLEEP;
            e_lvl         = lvl_wake;
         end
         OP_SCAN: begin
            pending_in[a] = 1'b0;
            if (count_ff[lvl_a] < CNT_W'(MAX_PROC)) begin
               fwe             = 1'b1;
               count_in[lvl_a] = count_ff[lvl_a] + CNT_W'(1);
            end
            emit    = 1'b1;
            e_ev    = EV_ENQ;
            e_cause = cause_ff[a];
         end
         OP_DISP_RD: begin
            frd_in  = {lvl_pick, head_ff[lvl_pick]};
            lsel_in = lvl_pick;
         end
         OP_DISP: begin
            head_in[lsel_ff]  = head_ff[lsel_ff] + SLOT_W'(1);
            count_in[lsel_ff] = count_ff[lsel_ff] - CNT_W'(1);
            run_in            = a;
            rem_in[a]         = b_a;
            if (lsel_ff == LVL_3) slice_in = b_a;
            else                  slice_in = (b_a < q_sel) ? b_a : q_sel;
            emit  = 1'b1;
            e_ev  = EV_DISP;
            e_lvl = lsel_ff;
         end
         OP_DONE: begin
            if (cur_ff != TIME_TOP) cur_in = cur_ff + TIME_W'(1);
            emit    = 1'b1;
            e_ev    = EV_DONE;
            e_num   = '0;
            e_lvl   = LVL_0;
            e_last  = 1'b1;
         end
         default: ;
      endcase
   end

   // status to the controller
   always_comb begin
      status.action     = rq_act_ff;
      status.slice_zero = (slice_ff == '0);
      status.slice_one  = (slice_ff == TIME_W'(1));
      status.rem_le1    = (rem_a <= TIME_W'(1));
      status.ends       = (bl_a <= CNT_W'(1));
      status.scan_live  = (cmd.idx < n_use);
      status.scan_hit   = active_ff[a] && pending_ff[a] && (next_ff[a] <= cur_ff);
      status.sum_more   = (cmd.idx < bl_a) && (cmd.idx < CNT_W'(MAX_PROC));
      status.pos_ok     = (rq_pos_ff < POS_W'(BURST_SLOTS - 1));
      status.disp_any   = (count_ff[0] != '0) || (count_ff[1] != '0) ||
                          (count_ff[2] != '0) || (count_ff[3] != '0);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff    <= CNT_W'(1);
         q0_ff        <= TIME_W'(2);
         q1_ff        <= TIME_W'(4);
         q2_ff        <= TIME_W'(8);
         cur_ff       <= '0;
         slice_ff     <= '0;
         run_ff       <= '0;
         active_ff    <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < 4; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PCOUNT: pcount_ff <= csr_wdata[CNT_W-1:0];
               CSR_Q0:     q0_ff     <= csr_wdata;
               CSR_Q1:     q1_ff     <= csr_wdata;
               default:    q2_ff     <= csr_wdata;
            endcase
         end
         cur_ff     <= cur_in;
         slice_ff   <= slice_in;
         run_ff     <= run_in;
         active_ff  <= active_in;
         pending_ff <= pending_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      level_in_to_ff: begin
         level_ff <= level_in;
         next_ff  <= next_in;
         cause_ff <= cause_in;
         bl_ff    <= bl_in;
         ptr_ff   <= ptr_in;
         rem_ff   <= rem_in;
         fa_ff    <= fa_in;
         tot_ff   <= tot_in;
      end
      sum_ff  <= sum_in;
      io_ff   <= io_in;
      lsel_ff <= lsel_in;
      brd_ff  <= brd_in;
      frd_ff  <= frd_in;
      if (cmd.op == OP_LATCH) begin
         rq_act_ff  <= req_action;
         rq_slot_ff <= req_process_index;
         rq_arr_ff  <= req_arrival_time;
         rq_lvl_ff  <= req_start_level;
         rq_cnt_ff  <= req_cpu_burst_count;
         rq_pos_ff  <= req_burst_slot;
         rq_len_ff  <= req_burst_length;
      end
      if (emit) begin
         rsp_event_res       <= e_ev;
         rsp_process_number  <= e_num;
         rsp_queue_level     <= e_lvl;
         rsp_enqueue_cause   <= e_cause;
         rsp_event_time      <= cur_ff;
         rsp_turnaround_time <= e_tt;
         rsp_waiting_time    <= e_wt;
         rsp_all_finished    <= ~|(active_in & use_mask);
         rsp_last            <= e_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/multilevel_feedback_queue_scheduler_top.sv
// Four-level feedback queue scheduler. Items are handled one at a time. A define
// spends most of its work zeroing the slot's 32-entry burst row through the
// single write port of the burst memory. A load re-sums the CPU total over the
// slot's remaining CPU bursts, one memory read at a time. A tick runs the enqueue
// scan over the slots in use, one slot at a time, takes a longer path when the
// running burst ends in a sleep, and waits whenever the result side stalls; it
// returns up to 19 result items, the last one flagged. No clearing pass follows
// reset.
// depends on mfqs_pkg, mfqs_ctrl and mfqs_dp
`default_nettype none

module multilevel_feedback_queue_scheduler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_process_index,
   input  wire logic [15:0] req_arrival_time,
   input  wire logic [1:0]  req_start_level,
   input  wire logic [4:0]  req_cpu_burst_count,
   input  wire logic [4:0]  req_burst_slot,
   input  wire logic [15:0] req_burst_length,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [3:0]       rsp_process_number,
   output logic [1:0]       rsp_queue_level,
   output logic [1:0]       rsp_enqueue_cause,
   output logic [15:0]      rsp_event_time,
   output logic [15:0]      rsp_turnaround_time,
   output logic [15:0]      rsp_waiting_time,
   output logic             rsp_all_finished,
   output logic             rsp_last
);
   import mfqs_pkg::*;

   mfqs_cmd_type    cmd;
   mfqs_status_type status;

   mfqs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   mfqs_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_action(req_action), .req_process_index(req_process_index),
      .req_arrival_time(req_arrival_time), .req_start_level(req_start_level),
      .req_cpu_burst_count(req_cpu_burst_count), .req_burst_slot(req_burst_slot),
      .req_burst_length(req_burst_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res), .rsp_process_number(rsp_process_number),
      .rsp_queue_level(rsp_queue_level), .rsp_enqueue_cause(rsp_enqueue_cause),
      .rsp_event_time(rsp_event_time), .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_waiting_time(rsp_waiting_time), .rsp_all_finished(rsp_all_finished),
      .rsp_last(rsp_last)
   );

   // an accepted item leaves the block busy in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken twice in a row");

   // the last flag marks exactly the tick-done item
   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_event_res == EV_DONE)))
      else $error("last flag on wrong item");

   // an item is only produced into a free result register
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TERM || cmd.op == OP_TIMEOUT || cmd.op == OP_SLEEP ||
       cmd.op == OP_SCAN || cmd.op == OP_DISP || cmd.op == OP_DONE) |-> status.out_free)
      else $error("result overwritten");

   // no tick done is issued while the previous tick done still waits
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_ready) |-> (cmd.op != OP_DONE))
      else $error("tick done issued over a pending item");

endmodule

`default_nettype wire
